FILE: sv/spl_pkg.sv
`default_nettype none
package spl_pkg;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_CURVE_ENABLE = 2'd1;
	localparam logic [1:0] CFG_PIXEL_SCALE  = 2'd2;

	localparam int COEF_W      = 40;
	localparam int AXIS_STAGES = 7;
	localparam logic [22:0] PIXEL_SCALE_RESET = 23'd65536;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a3;
	} axis_coef_t;

	typedef struct packed {
		logic       zero;
		logic       fin;
		logic       curve;
		logic       s_is0;
		logic       s_is1;
		logic       last;
		logic       neg;
		logic [8:0] seg;
		logic [15:0] t;
	} samp_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/spline_path_sampler.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  tuser func, tdata index/x/y/progress
// m        out  m_tvalid/m_tready  tuser saturated, tdata out_x/out_y
// cfg      in   cfg_we             cfg_index, cfg_data
// one word per cycle in and out while the output is not stalled; the valid bit
// passes v_s1, v_s2 and the ax_vld_s shift register before it drives m_tvalid
// the table sits in four banks by index mod 4, so a sample reads its four
// neighboring points in a single read; at most one multiplier per axis per stage
// arst_n resets valid bits and config registers; table contents stay undefined
// the whole pipe advances when the output register is empty or taken
`default_nettype none
module spline_path_sampler
	import spl_pkg::*;
#(
	parameter int MAX_POINTS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // index, point_x, point_y, progress, zero fill
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // out_x, out_y
	output logic             m_tuser,  // saturated
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [22:0] cfg_data
);
	localparam int BANK_D = (MAX_POINTS + 3) / 4;
	localparam int AW = BANK_D > 1 ? $clog2(BANK_D) : 1;

	logic [7:0]  point_count_q;
	logic        curve_enable_q;
	logic [22:0] pixel_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q  <= '0;
			curve_enable_q <= 1'b0;
			pixel_scale_q  <= PIXEL_SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POINT_COUNT:  point_count_q  <= cfg_data[7:0];
				CFG_CURVE_ENABLE: curve_enable_q <= cfg_data[0];
				CFG_PIXEL_SCALE:  pixel_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en, acc;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc = s_tvalid && en;

	// input fields
	logic [6:0]         idx;
	logic signed [31:0] px, py;
	logic signed [18:0] prog;
	assign idx  = s_tdata[6:0];
	assign px   = s_tdata[38:7];
	assign py   = s_tdata[70:39];
	assign prog = s_tdata[89:71];

	// write path with near-zero snap
	logic [31:0] ax, ay;
	logic [11:0] sq;
	logic        tiny, wr_ok;
	assign ax = px[31] ? 32'(-px) : 32'(px);
	assign ay = py[31] ? 32'(-py) : 32'(py);
	assign sq = 12'(ax[5:0] * ax[5:0]) + 12'(ay[5:0] * ay[5:0]);
	assign tiny = (ax <= 32'd32) && (ay <= 32'd32) && (sq <= 12'd1024);
	assign wr_ok = acc && (s_tuser == FUNC_WRITE) && ({2'b00, idx} < 9'(MAX_POINTS));

	// segment search
	logic [8:0]  n0, seg_raw, seg;
	logic [18:0] mag;
	logic [24:0] u;
	logic        fin;
	samp_ctrl_t  ctl0;
	always_comb begin
		n0 = ({1'b0, point_count_q} < 9'(MAX_POINTS)) ? {1'b0, point_count_q}
			: 9'(MAX_POINTS);
		mag = prog[18] ? 19'(-prog) : 19'(prog);
		u = 25'(mag[15:0] * n0);
		seg_raw = u[24:16];
		fin = (mag[18:16] != 3'd0) || (seg_raw >= n0);
		seg = fin ? n0 - 9'd1 : seg_raw;
		ctl0.zero  = (s_tuser == FUNC_WRITE) || (n0 == 9'd0);
		ctl0.fin   = fin;
		ctl0.curve = curve_enable_q && (n0 > 9'd1);
		ctl0.s_is0 = (seg == 9'd0);
		ctl0.s_is1 = (seg == 9'd1);
		ctl0.last  = ({1'b0, seg} + 10'd1) >= {1'b0, n0};
		ctl0.neg   = prog[18];
		ctl0.seg   = seg;
		ctl0.t     = fin ? 16'd0 : u[15:0];
	end

	samp_ctrl_t ctl_s1, ctl_s2;
	logic v_s1, v_s2;
	logic [AXIS_STAGES-1:0] ax_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ax_vld_s <= '0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			ax_vld_s <= {ax_vld_s[AXIS_STAGES-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl0;
			ctl_s2 <= ctl_s1;
		end
	end

	// banked table: bank b holds indices with index mod 4 == b
	logic [9:0]  base;
	logic [63:0] rd [4];
	assign base = {1'b0, ctl_s1.seg} - 10'd2;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [1:0] off;
		logic [9:0] k;
		assign off = 2'(b) - base[1:0];
		assign k = base + {8'b0, off};
		spl_ram #(.WIDTH(64), .DEPTH(BANK_D)) u_ram (
			.clk   (clk),
			.we    (wr_ok && (idx[1:0] == 2'(b))),
			.waddr (AW'(idx[6:2])),
			.wdata (tiny ? 64'd0 : {py, px}),
			.re    (en),
			.raddr (AW'(k[9:2])),
			.rdata (rd[b])
		);
	end

	// window q0..q3 = table[seg-2 .. seg+1]
	logic [63:0] q [4];
	for (genvar j = 0; j < 4; j++) begin : g_win
		assign q[j] = rd[2'(ctl_s2.seg[1:0] + 2'(j + 2))];
	end

	function automatic axis_coef_t coef_f(input logic signed [31:0] q0, q1, q2, q3,
			input samp_ctrl_t c);
		axis_coef_t r;
		logic signed [COEF_W-1:0] p0, p1, p2, p3, e1, e2, e3;
		e1 = COEF_W'(q1);
		e2 = COEF_W'(q2);
		e3 = COEF_W'(q3);
		r = '0;
		p0 = '0;
		p1 = '0;
		p2 = '0;
		p3 = '0;
		if (c.zero) begin
			r = '0;
		end else if (c.fin) begin
			r.a0 = 2 * e2;
		end else if (c.curve) begin
			if (c.s_is0) begin
				p0 = -e2;
				p1 = '0;
				p2 = e2;
				p3 = e3;
			end else begin
				p0 = c.s_is1 ? '0 : COEF_W'(q0);
				p1 = e1;
				p2 = e2;
				p3 = c.last ? 2 * e2 - e1 : e3;
			end
			r.a0 = 2 * p1;
			r.a1 = p2 - p0;
			r.a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
			r.a3 = -p0 + 3 * p1 - 3 * p2 + p3;
		end else if (c.s_is0) begin
			r.a1 = 2 * e2;
		end else begin
			r.a0 = 2 * e1;
			r.a1 = 2 * (e2 - e1);
		end
		return r;
	endfunction

	axis_coef_t cx, cy;
	assign cx = coef_f(q[0][31:0], q[1][31:0], q[2][31:0], q[3][31:0], ctl_s2);
	assign cy = coef_f(q[0][63:32], q[1][63:32], q[2][63:32], q[3][63:32], ctl_s2);

	logic signed [31:0] out_x, out_y;
	logic sat_x, sat_y;

	spl_axis u_ax_x (
		.clk   (clk),
		.en    (en),
		.coef  (cx),
		.t     (ctl_s2.t),
		.neg   (ctl_s2.neg),
		.scale (pixel_scale_q),
		.value (out_x),
		.sat   (sat_x)
	);

	spl_axis u_ax_y (
		.clk   (clk),
		.en    (en),
		.coef  (cy),
		.t     (ctl_s2.t),
		.neg   (ctl_s2.neg),
		.scale (pixel_scale_q),
		.value (out_y),
		.sat   (sat_y)
	);

	assign m_tvalid = ax_vld_s[AXIS_STAGES-1];
	assign m_tdata  = {out_y, out_x};
	assign m_tuser  = sat_x || sat_y;

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (out_x == 32'sh7FFF_FFFF) || (out_x == 32'sh8000_0000)
			|| (out_y == 32'sh7FFF_FFFF) || (out_y == 32'sh8000_0000))
		else $error("saturated flag without clamped coordinate");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ctl_s1.zero |-> ctl_s1.last == (({1'b0, ctl_s1.seg} + 10'd1)
			>= {1'b0, ((({1'b0, point_count_q} < 9'(MAX_POINTS)) ? {1'b0, point_count_q}
			: 9'(MAX_POINTS)))}))
		else $error("segment beyond points in use");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed under stall");

	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && ctl_s2.zero |-> (cx == '0) && (cy == '0))
		else $error("write or empty sample with nonzero coefficients");

endmodule
`default_nettype wire

FILE: sv/spl_ram.sv
`default_nettype none
module spl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: sv/spl_axis.sv
`default_nettype none
module spl_axis
	import spl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire axis_coef_t         coef,
	input  wire logic [15:0]        t,
	input  wire logic               neg,
	input  wire logic [22:0]        scale,
	output logic signed [31:0]      value,
	output logic                    sat
);
	axis_coef_t c_s1;
	logic [15:0] t_s1, t_s2, t_s3;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic signed [COEF_W-1:0] a0_s2, a1_s2, a2_s2, a0_s3, a1_s3, a0_s4;
	logic signed [56:0] p_s2, p_s3, p_s4;
	logic signed [COEF_W-1:0] h_s5;
	logic signed [63:0] m_s6;

	function automatic logic signed [COEF_W-1:0] rnd(input logic signed [56:0] v);
		logic signed [56:0] w;
		w = v + 57'sd32768;
		return w[55:16];
	endfunction

	logic signed [COEF_W-1:0] h2, h1, h0;
	logic signed [63:0] mr;
	logic signed [46:0] r;

	assign h2 = a2_s2 + rnd(p_s2);
	assign h1 = a1_s3 + rnd(p_s3);
	assign h0 = a0_s4 + rnd(p_s4);
	assign mr = m_s6 + 64'sd65536;
	assign r  = mr[63:17];

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= coef;
			t_s1   <= t;
			neg_s1 <= neg;

			p_s2   <= c_s1.a3 * $signed({1'b0, t_s1});
			a0_s2  <= c_s1.a0;
			a1_s2  <= c_s1.a1;
			a2_s2  <= c_s1.a2;
			t_s2   <= t_s1;
			neg_s2 <= neg_s1;

			p_s3   <= h2 * $signed({1'b0, t_s2});
			a0_s3  <= a0_s2;
			a1_s3  <= a1_s2;
			t_s3   <= t_s2;
			neg_s3 <= neg_s2;

			p_s4   <= h1 * $signed({1'b0, t_s3});
			a0_s4  <= a0_s3;
			neg_s4 <= neg_s3;

			h_s5   <= neg_s4 ? -h0 : h0;

			m_s6   <= h_s5 * $signed({1'b0, scale});

			if (r > 47'sd2147483647) begin
				value <= 32'sh7FFF_FFFF;
				sat   <= 1'b1;
			end else if (r < -47'sd2147483648) begin
				value <= 32'sh8000_0000;
				sat   <= 1'b1;
			end else begin
				value <= r[31:0];
				sat   <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
